### rtl/chkh_pkg.sv
// shared types and constants for the multilane content key hash
`timescale 1ns / 1ps
`default_nettype none
package chkh_pkg;

    typedef logic [63:0] word_t;

    // request into the shared multiplier
    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
    } mul_req_t;

    localparam int    DEFAULT_LANES = 8;
    localparam logic [15:0] VERSION_RESET = 16'd1;

    localparam logic  KIND_START = 1'b0;
    localparam logic  KIND_DATA  = 1'b1;

    localparam word_t MIX_C1    = 64'hff51afd7ed558ccd;
    localparam word_t MIX_C2    = 64'hc4ceb9fe1a85ec53;
    localparam word_t GOLDEN    = 64'h9e3779b97f4a7c15;
    localparam word_t BODY_MUL  = 64'h9fb21c651e98df25;
    localparam word_t FNV_PRIME = 64'h00000100000001b3;

    localparam int MIX_SHIFT  = 33;
    localparam int BODY_SHIFT = 29;

endpackage
`default_nettype wire

### rtl/chkh_mul.sv
// iterative 64x64 low-half multiplier built on one 32x32 multiplier
`timescale 1ns / 1ps
`default_nettype none
module chkh_mul
    import chkh_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output logic          done,
    output word_t         product
);

    word_t       a_reg, a_next;
    word_t       b_reg, b_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] p0_reg, p0_next;
    logic [31:0] cross_reg, cross_next;
    word_t       prod_reg, prod_next;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] mult;

    // operand select for the partial product of this step
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                op_a = a_reg[31:0];
                op_b = b_reg[31:0];
            end
            2'd1:
            begin
                op_a = a_reg[31:0];
                op_b = b_reg[63:32];
            end
            default:
            begin
                op_a = a_reg[63:32];
                op_b = b_reg[31:0];
            end
        endcase
        mult = op_a * op_b;
    end

    // step sequencing
    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        p0_next    = p0_reg;
        cross_next = cross_reg;
        prod_next  = prod_reg;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            step_next = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                2'd0:
                begin
                    p0_next   = mult;
                    step_next = 2'd1;
                end
                2'd1:
                begin
                    cross_next = mult[31:0];
                    step_next  = 2'd2;
                end
                2'd2:
                begin
                    cross_next = cross_reg + mult[31:0];
                    step_next  = 2'd3;
                end
                default:
                begin
                    prod_next = p0_reg + {cross_reg, 32'd0};
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        p0_reg    <= p0_next;
        cross_reg <= cross_next;
        prod_reg  <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule
`default_nettype wire

### rtl/chkh_lane_mem.sv
// lane accumulator memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module chkh_lane_mem
    import chkh_pkg::*;
#(
    parameter int LANES  = DEFAULT_LANES,
    parameter int IDX_W  = (LANES > 1) ? $clog2(LANES) : 1
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire word_t            wdata,
    input  wire logic [IDX_W-1:0] raddr,
    output word_t                 rdata
);

    word_t mem [LANES];
    word_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/multilane_content_key_hash_core.sv
// top level of the multilane content key hash: control sequencer and datapath
// start item: 2 fmix rounds, then the lane memory is seeded one lane per cycle
// body word: memory read, shared multiplier, write back, check
// tail word: lane 0 read, then each valid byte through the shared multiplier
// finish: every lane is folded in through fmix, then the key sits in an output register
// reset clears all control state and sets format_version to 1; one item is worked at a time
`timescale 1ns / 1ps
`default_nettype none
module multilane_content_key_hash_core
    import chkh_pkg::*;
#(
    parameter int LANES = DEFAULT_LANES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [31:0] source_format,
    input  wire logic [31:0] target_format,
    input  wire logic [15:0] width,
    input  wire logic [15:0] height,
    input  wire logic [31:0] byte_length,
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  valid_bytes,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      key
);

    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LANES - 1);
    localparam logic [32:0] BLOCK_BYTES = 33'(8 * LANES);

    typedef enum logic [4:0] {
        S_IDLE,
        S_SEED_A,
        S_SEED_B,
        S_SEED_C,
        S_INIT,
        S_FM0,
        S_FM1,
        S_FM2,
        S_BODY_MUL,
        S_BODY_W,
        S_TAIL_LD,
        S_TAIL_MUL,
        S_TAIL_W,
        S_CHECK,
        S_FIN_START,
        S_FIN_RD,
        S_FIN_NEXT,
        S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    logic [15:0]      version_reg, version_next;
    logic             active_reg, active_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      consumed_reg, consumed_next;
    logic [IDX_W-1:0] lane_idx_reg, lane_idx_next;
    logic [IDX_W-1:0] sweep_reg, sweep_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [2:0]       bi_reg, bi_next;
    word_t            seed_reg, seed_next;
    word_t            x_reg, x_next;
    word_t            acc_reg, acc_next;
    logic [31:0]      hdr_reg, hdr_next;
    word_t            data_reg, data_next;
    logic             out_valid_reg, out_valid_next;
    word_t            key_reg, key_next;

    mul_req_t         mreq;
    logic             mdone;
    word_t            mprod;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    word_t            mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    word_t            mem_rdata;

    logic             accept;
    logic             in_body;
    logic [3:0]       vb_cnt;
    logic [31:0]      remaining;
    logic [3:0]       tail_cnt;
    word_t            mix_x;
    word_t            mix_p;
    word_t            body_v;

    chkh_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .done    (mdone),
        .product (mprod)
    );

    chkh_lane_mem #(
        .LANES (LANES),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // input handshake and derived values
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign in_body  = (lane_idx_reg != '0) ||
                      (({1'b0, consumed_reg} + BLOCK_BYTES) <= {1'b0, len_reg});
    assign vb_cnt   = (valid_bytes == 4'd0 || valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
    assign remaining = len_reg - consumed_reg;
    assign tail_cnt = (remaining < {28'd0, vb_cnt}) ? remaining[3:0] : vb_cnt;
    assign mix_x    = x_reg ^ (x_reg >> MIX_SHIFT);
    assign mix_p    = mprod ^ (mprod >> MIX_SHIFT);
    assign body_v   = mprod ^ (mprod >> BODY_SHIFT);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        version_next   = version_reg;
        active_next    = active_reg;
        len_next       = len_reg;
        consumed_next  = consumed_reg;
        lane_idx_next  = lane_idx_reg;
        sweep_next     = sweep_reg;
        cnt_next       = cnt_reg;
        bi_next        = bi_reg;
        seed_next      = seed_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        hdr_next       = hdr_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg && out_stall;
        key_next       = key_reg;
        mreq           = '0;
        mem_we         = 1'b0;
        mem_waddr      = lane_idx_reg;
        mem_wdata      = x_reg;
        mem_raddr      = lane_idx_reg;

        if (cfg_we)
        begin
            version_next = cfg_wdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_START)
                    begin
                        x_next        = {version_reg, 48'd0} ^ {16'd0, source_format, 16'd0}
                                        ^ {32'd0, target_format};
                        hdr_next      = {width, height};
                        len_next      = byte_length;
                        consumed_next = '0;
                        lane_idx_next = '0;
                        active_next   = 1'b0;
                        ret_next      = S_SEED_A;
                        state_next    = S_FM0;
                    end
                    else if (active_reg)
                    begin
                        data_next = data_word;
                        if (in_body)
                        begin
                            mem_raddr  = lane_idx_reg;
                            state_next = S_BODY_MUL;
                        end
                        else
                        begin
                            mem_raddr  = '0;
                            cnt_next   = tail_cnt;
                            bi_next    = '0;
                            state_next = S_TAIL_LD;
                        end
                    end
                end
            end

            // second seed round
            S_SEED_A:
            begin
                x_next     = x_reg ^ {16'd0, hdr_reg[31:16], 16'd0, hdr_reg[15:0]};
                ret_next   = S_SEED_B;
                state_next = S_FM0;
            end
            S_SEED_B:
            begin
                seed_next  = x_reg;
                acc_next   = x_reg + GOLDEN;
                sweep_next = '0;
                state_next = S_INIT;
            end
            S_SEED_C:
            begin
                state_next = S_INIT;
            end

            // seed the lanes, one per cycle
            S_INIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = acc_reg;
                acc_next   = acc_reg + GOLDEN;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_IDX)
                begin
                    if (len_reg == '0)
                    begin
                        state_next = S_FIN_START;
                    end
                    else
                    begin
                        active_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end

            // fmix64 on x_reg, back to ret_reg
            S_FM0:
            begin
                mreq.start = 1'b1;
                mreq.a     = mix_x;
                mreq.b     = MIX_C1;
                state_next = S_FM1;
            end
            S_FM1:
            begin
                if (mdone)
                begin
                    mreq.start = 1'b1;
                    mreq.a     = mix_p;
                    mreq.b     = MIX_C2;
                    state_next = S_FM2;
                end
            end
            S_FM2:
            begin
                if (mdone)
                begin
                    x_next     = mix_p;
                    state_next = ret_reg;
                end
            end

            // body word into its lane
            S_BODY_MUL:
            begin
                mreq.start = 1'b1;
                mreq.a     = mem_rdata ^ data_reg;
                mreq.b     = BODY_MUL;
                state_next = S_BODY_W;
            end
            S_BODY_W:
            begin
                if (mdone)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = lane_idx_reg;
                    mem_wdata     = body_v;
                    consumed_next = consumed_reg + 32'd8;
                    lane_idx_next = (lane_idx_reg == LAST_IDX) ? '0 : lane_idx_reg + 1'b1;
                    state_next    = S_CHECK;
                end
            end

            // tail bytes folded into lane 0
            S_TAIL_LD:
            begin
                x_next     = mem_rdata;
                state_next = S_TAIL_MUL;
            end
            S_TAIL_MUL:
            begin
                mreq.start = 1'b1;
                mreq.a     = x_reg ^ {56'd0, data_reg[bi_reg*8 +: 8]};
                mreq.b     = FNV_PRIME;
                state_next = S_TAIL_W;
            end
            S_TAIL_W:
            begin
                if (mdone)
                begin
                    x_next  = mprod;
                    bi_next = bi_reg + 1'b1;
                    if ({1'b0, bi_reg} + 4'd1 == cnt_reg)
                    begin
                        mem_we        = 1'b1;
                        mem_waddr     = '0;
                        mem_wdata     = mprod;
                        consumed_next = consumed_reg + {28'd0, cnt_reg};
                        state_next    = S_CHECK;
                    end
                    else
                    begin
                        state_next = S_TAIL_MUL;
                    end
                end
            end

            S_CHECK:
            begin
                if (consumed_reg >= len_reg)
                begin
                    active_next = 1'b0;
                    state_next  = S_FIN_START;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // finish through every lane
            S_FIN_START:
            begin
                x_next     = seed_reg ^ {32'd0, len_reg};
                sweep_next = '0;
                mem_raddr  = '0;
                state_next = S_FIN_RD;
            end
            S_FIN_RD:
            begin
                x_next     = x_reg ^ mem_rdata;
                ret_next   = S_FIN_NEXT;
                state_next = S_FM0;
            end
            S_FIN_NEXT:
            begin
                if (sweep_reg == LAST_IDX)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_raddr  = sweep_reg + 1'b1;
                    sweep_next = sweep_reg + 1'b1;
                    state_next = S_FIN_RD;
                end
            end

            // hand the key to the output register
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    key_next       = x_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            version_reg   <= VERSION_RESET;
            active_reg    <= 1'b0;
            len_reg       <= '0;
            consumed_reg  <= '0;
            lane_idx_reg  <= '0;
            sweep_reg     <= '0;
            cnt_reg       <= '0;
            bi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            version_reg   <= version_next;
            active_reg    <= active_next;
            len_reg       <= len_next;
            consumed_reg  <= consumed_next;
            lane_idx_reg  <= lane_idx_next;
            sweep_reg     <= sweep_next;
            cnt_reg       <= cnt_next;
            bi_reg        <= bi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        seed_reg <= seed_next;
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        hdr_reg  <= hdr_next;
        data_reg <= data_next;
        key_reg  <= key_next;
    end

    assign out_valid = out_valid_reg;
    assign key       = key_reg;

`ifndef ASSERT_OFF
    // an open stream always has bytes left while waiting for input
    a_active_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && active_reg) |-> (consumed_reg < len_reg))
        else $error("open stream with no bytes left");

    // multiplier results only arrive where the sequencer waits for them
    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        mdone |-> (state_reg == S_FM1 || state_reg == S_FM2 ||
                   state_reg == S_BODY_W || state_reg == S_TAIL_W))
        else $error("multiplier result with no consumer");

    // a new key transaction comes only from the emit step
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("key raised outside emit");
`endif

endmodule
`default_nettype wire

### verif/multilane_content_key_hash_core_tb.sv
// self-checking testbench for the multilane content key hash core
`timescale 1ns / 1ps
`default_nettype none
module multilane_content_key_hash_core_tb;
    import chkh_pkg::*;

    localparam int NUM_LANES = 8;
    localparam int BLOCK_BYTES = 8 * NUM_LANES;

    typedef struct packed {
        logic        kind;
        logic [31:0] source_format;
        logic [31:0] target_format;
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] byte_length;
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
    } hash_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [31:0] source_format;
    logic [31:0] target_format;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] byte_length;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] key;

    multilane_content_key_hash_core #(.LANES(NUM_LANES)) u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .source_format(source_format), .target_format(target_format),
        .width(width), .height(height), .byte_length(byte_length),
        .data_word(data_word), .valid_bytes(valid_bytes),
        .out_valid(out_valid), .out_stall(out_stall), .key(key)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // predictor state
    logic [15:0] pred_version;
    word_t       pred_seed;
    word_t       pred_lane [NUM_LANES];
    logic [31:0] pred_total;
    logic [31:0] pred_consumed;
    logic        pred_active;

    hash_item_t  pending_items [$];
    word_t       expected_keys [$];
    int          error_count;

    function automatic word_t fmix(input word_t x);
        x = x ^ (x >> MIX_SHIFT);
        x = x * MIX_C1;
        x = x ^ (x >> MIX_SHIFT);
        x = x * MIX_C2;
        x = x ^ (x >> MIX_SHIFT);
        return x;
    endfunction

    function automatic word_t finish_content_key();
        word_t h;
        h = pred_seed ^ {32'd0, pred_total};
        for (int l = 0; l < NUM_LANES; l++)
            h = fmix(h ^ pred_lane[l]);
        return h;
    endfunction

    // update the predicted state for one accepted transaction
    task automatic predict_key(input hash_item_t it);
        word_t       s;
        logic [31:0] body_end;
        logic [31:0] cnt;
        int          idx;
        if (it.kind == KIND_START)
        begin
            s = fmix({pred_version, 48'd0} ^ {16'd0, it.source_format, 16'd0}
                     ^ {32'd0, it.target_format});
            s = fmix(s ^ {16'd0, it.width, 32'd0} ^ {48'd0, it.height});
            pred_seed = s;
            for (int l = 0; l < NUM_LANES; l++)
                pred_lane[l] = s + word_t'(l + 1) * GOLDEN;
            pred_total = it.byte_length;
            pred_consumed = 0;
            if (pred_total == 0)
            begin
                pred_active = 1'b0;
                expected_keys.push_back(finish_content_key());
            end
            else
                pred_active = 1'b1;
            return;
        end
        if (!pred_active)
            return;
        body_end = (pred_total / BLOCK_BYTES) * BLOCK_BYTES;
        if (pred_consumed < body_end)
        begin
            idx = (pred_consumed / 8) % NUM_LANES;
            s = (pred_lane[idx] ^ it.data_word) * BODY_MUL;
            pred_lane[idx] = s ^ (s >> BODY_SHIFT);
            pred_consumed += 8;
        end
        else
        begin
            cnt = {28'd0, it.valid_bytes};
            if (cnt == 0 || cnt > 8)
                cnt = 8;
            if (cnt > pred_total - pred_consumed)
                cnt = pred_total - pred_consumed;
            for (int i = 0; i < cnt; i++)
                pred_lane[0] = (pred_lane[0] ^ {56'd0, it.data_word[8*i +: 8]}) * FNV_PRIME;
            pred_consumed += cnt;
        end
        if (pred_consumed >= pred_total)
        begin
            pred_active = 1'b0;
            expected_keys.push_back(finish_content_key());
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // driver
    int drive_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= 1'b0;
            source_format <= '0;
            target_format <= '0;
            width <= '0;
            height <= '0;
            byte_length <= '0;
            data_word <= '0;
            valid_bytes <= '0;
            drive_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_key(pending_items.pop_front());
                drive_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 11);
            end
            if (in_valid && in_stall)
                ;
            else if (drive_gap > 0)
            begin
                drive_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_valid <= 1'b1;
                kind <= pending_items[0].kind;
                source_format <= pending_items[0].source_format;
                target_format <= pending_items[0].target_format;
                width <= pending_items[0].width;
                height <= pending_items[0].height;
                byte_length <= pending_items[0].byte_length;
                data_word <= pending_items[0].data_word;
                valid_bytes <= pending_items[0].valid_bytes;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and receiver stalls
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_keys.size() == 0)
                    report_mismatch($sformatf("unexpected key %h", key));
                else if (key !== expected_keys[0])
                begin
                    report_mismatch($sformatf("key %h, want %h", key, expected_keys[0]));
                    void'(expected_keys.pop_front());
                end
                else
                    void'(expected_keys.pop_front());
                stall_left = $urandom_range(0, 1) ? 0 : $urandom_range(0, 11);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    function automatic hash_item_t start_item(input logic [31:0] len);
        hash_item_t it;
        it.kind = KIND_START;
        it.source_format = $urandom;
        it.target_format = $urandom;
        it.width = 16'($urandom);
        it.height = 16'($urandom);
        it.byte_length = len;
        it.data_word = {$urandom, $urandom};
        it.valid_bytes = 4'($urandom);
        return it;
    endfunction

    function automatic hash_item_t data_item(input logic [3:0] vb);
        hash_item_t it;
        it = start_item($urandom);
        it.kind = KIND_DATA;
        it.valid_bytes = vb;
        return it;
    endfunction

    // queue a well-formed stream, full words then any final partial one, or with noisy_tail one item per byte left
    task automatic queue_stream(input int len, input bit noisy_tail);
        int left;
        left = len;
        pending_items.push_back(start_item(32'(len)));
        while (left > 0)
        begin
            if (left >= 8)
                pending_items.push_back(data_item(noisy_tail ? 4'($urandom) : 4'd8));
            else
                pending_items.push_back(data_item(noisy_tail ? 4'($urandom)
                                                             : 4'(left)));
            left -= noisy_tail ? 1 : 8;
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || in_valid || expected_keys.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_version(input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        pred_version = v;
    endtask

    // stimulus
    initial
    begin
        hash_item_t it;
        logic [15:0] versions [4];
        versions = '{16'h0000, 16'hffff, 16'h8001, 16'h0001};
        error_count = 0;
        pred_version = VERSION_RESET;
        pred_seed = 0;
        pred_total = 0;
        pred_consumed = 0;
        pred_active = 1'b0;
        for (int l = 0; l < NUM_LANES; l++)
            pred_lane[l] = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 16'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset version, idle data, zero length, extremes
        pending_items.push_back(data_item(4'd8));
        it = start_item(0);
        it.source_format = '1; it.target_format = '1; it.width = '1; it.height = '1;
        pending_items.push_back(it);
        it = start_item(0);
        it.source_format = 0; it.target_format = 0; it.width = 0; it.height = 0;
        pending_items.push_back(it);
        pending_items.push_back(start_item(3));
        it = data_item(4'd0);
        it.data_word = '1;
        pending_items.push_back(it);
        pending_items.push_back(start_item(5));
        pending_items.push_back(data_item(4'd15));
        // start while active drops the open key
        pending_items.push_back(start_item(100));
        pending_items.push_back(data_item(4'd8));
        queue_stream(64, 0);
        queue_stream(67, 0);
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_version(versions[ph]);
            for (int n = 0; n < 350; )
            begin
                case ($urandom_range(0, 9))
                    0: begin pending_items.push_back(data_item(4'($urandom))); n++; end
                    1: begin pending_items.push_back(start_item($urandom)); n++; end
                    2: begin pending_items.push_back(start_item(0)); n++; end
                    3: begin
                        queue_stream($urandom_range(1, 20), 1);
                        n += 10;
                    end
                    4: begin
                        queue_stream($urandom_range(128, 200), 0);
                        n += 25;
                    end
                    default: begin
                        queue_stream($urandom_range(1, 80), 0);
                        n += 6;
                    end
                endcase
            end
            wait_idle();
        end
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // timeout
    initial
    begin
        #40ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
